FILE: sv/frame_rotate_90_top_assert.svh
// Assertion macros used by the frame rotator RTL.
// No dependencies; pulled in by the files that carry assertions.
`ifndef FRAME_ROTATE_90_TOP_ASSERT_SVH
`define FRAME_ROTATE_90_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FR90_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FR90_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/fr90_pkg.sv
// Package for the 90-degree frame rotator: sizes, codes, types and helpers.
// No dependencies; used by the interfaces and every module of the block.
package fr90_pkg;

   localparam int MAX_DIM      = 256;
   localparam int PIXEL_BITS   = 24;
   localparam int CFG_DIM_BITS = 9;
   localparam int DIM_BITS     = $clog2(MAX_DIM + 1);
   localparam int COORD_BITS   = $clog2(MAX_DIM);
   localparam int ADDR_BITS    = $clog2(MAX_DIM * MAX_DIM);
   localparam int PROD_BITS    = 2 * DIM_BITS;
   localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = CFG_DIM_BITS;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOCKWISE = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } fr90_state_type;

   typedef struct packed {
      logic load;     // load beat accepted
      logic drain;    // drain beat accepted
      logic capture;  // move store read data into the output register
   } fr90_cmd_type;

   // Dimension as used: 0 acts as 1, above MAX_DIM clamps.
   function automatic logic [DIM_BITS-1:0] eff_dim(input logic [CFG_DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

endpackage

FILE: sv/fr90_if.sv
// Handshake channels of the frame rotator: request and response.
// Depends on fr90_pkg for payload widths.
interface fr90_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [fr90_pkg::PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output mode, output pixel_in, input ready);
   modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface fr90_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fr90_pkg::PIXEL_BITS-1:0] pixel_out;
   logic                            last;
   logic                            status;

   modport source (output valid, output pixel_out, output last, output status, input ready);
   modport sink   (input valid, input pixel_out, input last, input status, output ready);
endinterface

FILE: sv/fr90_ctrl.sv
// Frame rotator controller: beat handshakes, read sequencing, output slot.
// Depends on fr90_pkg and frame_rotate_90_top_assert.svh.
`include "frame_rotate_90_top_assert.svh"

module fr90_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output fr90_pkg::fr90_cmd_type cmd
);

   fr90_pkg::fr90_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fr90_pkg::ST_IDLE: begin
            if (cmd.drain) state_in = fr90_pkg::ST_READ;
         end
         fr90_pkg::ST_READ: begin
            state_in = fr90_pkg::ST_IDLE;
         end
         default: state_in = fr90_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         fr90_pkg::ST_IDLE: begin
            // drains wait for a free output slot, loads never do
            req_ready = (req_mode == fr90_pkg::MODE_LOAD) || !rsp_valid_ff;
            cmd.load  = req_valid && req_ready && (req_mode == fr90_pkg::MODE_LOAD);
            cmd.drain = req_valid && req_ready && (req_mode == fr90_pkg::MODE_DRAIN);
         end
         fr90_pkg::ST_READ: begin
            cmd.capture = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fr90_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FR90_ASSERT_NEXT(a_drain_reads, clock, reset, cmd.drain, state_ff == fr90_pkg::ST_READ, "drain beat did not start a store read")
   `FR90_ASSERT_SAME(a_slot_free, clock, reset, state_ff == fr90_pkg::ST_READ, !rsp_valid_ff, "output slot busy when read data lands")
   `FR90_ASSERT_NEXT(a_capture_shows, clock, reset, cmd.capture, rsp_valid_ff, "captured result not presented")
   `FR90_ASSERT_SAME(a_load_idle, clock, reset, cmd.load, state_ff == fr90_pkg::ST_IDLE, "load taken during a read")

endmodule

FILE: sv/fr90_dp.sv
// Frame rotator datapath: config registers, load/drain counters,
// rotated address, frame store and output register. Depends on fr90_pkg.
module fr90_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  fr90_pkg::fr90_cmd_type             cmd,
   input  logic [fr90_pkg::PIXEL_BITS-1:0]    pixel_in,
   input  logic                               csr_we,
   input  logic [fr90_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fr90_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output logic [fr90_pkg::PIXEL_BITS-1:0]    pixel_out,
   output logic                               last,
   output logic                               status
);

   localparam int DB = fr90_pkg::DIM_BITS;
   localparam int CB = fr90_pkg::COORD_BITS;
   localparam int AB = fr90_pkg::ADDR_BITS;
   localparam int PB = fr90_pkg::PROD_BITS;

   logic [fr90_pkg::CFG_DIM_BITS-1:0] width_ff, width_in;
   logic [fr90_pkg::CFG_DIM_BITS-1:0] height_ff, height_in;
   logic                              cw_ff, cw_in;
   logic [CB-1:0]                     col_ff, col_in;
   logic [DB-1:0]                     row_ff, row_in;
   logic                              full_ff, full_in;
   logic [AB-1:0]                     pos_ff, pos_in;

   logic [fr90_pkg::PIXEL_BITS-1:0] store [fr90_pkg::STORE_DEPTH];
   logic [fr90_pkg::PIXEL_BITS-1:0] rd_data_ff;
   logic                            rd_last_ff;
   logic                            rd_nrdy_ff;
   logic [fr90_pkg::PIXEL_BITS-1:0] pixel_out_ff;
   logic                            last_ff;
   logic                            status_ff;

   logic [DB-1:0] w, h;
   logic [DB-1:0] mul_a, add_b;
   logic [PB-1:0] prod, total;
   logic [AB-1:0] wr_addr;
   logic          store_we;
   logic          is_last;
   logic          cfg_hit;

   assign w = fr90_pkg::eff_dim(width_ff);
   assign h = fr90_pkg::eff_dim(height_ff);

   // rotated address: cw x*H+(H-1-y), ccw (W-1-x)*H+y
   assign mul_a   = cw_ff ? DB'(col_ff) : (w - DB'(1) - DB'(col_ff));
   assign add_b   = cw_ff ? (h - DB'(1) - row_ff) : row_ff;
   assign prod    = PB'(mul_a) * PB'(h);
   assign wr_addr = AB'(prod + PB'(add_b));

   assign total    = PB'(w) * PB'(h);
   assign is_last  = (PB'(pos_ff) + PB'(1)) >= total;
   assign store_we = cmd.load && !full_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cw_in     = cw_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            fr90_pkg::CSR_WIDTH: begin
               width_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            fr90_pkg::CSR_HEIGHT: begin
               height_in = csr_wdata;
               cfg_hit   = 1'b1;
            end
            fr90_pkg::CSR_CLOCKWISE: begin
               cw_in   = csr_wdata[0];
               cfg_hit = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      full_in = full_ff;
      pos_in  = pos_ff;
      if (cfg_hit) begin
         col_in  = '0;
         row_in  = '0;
         full_in = 1'b0;
         pos_in  = '0;
      end else if (store_we) begin
         if (DB'(col_ff) == w - DB'(1)) begin
            col_in = '0;
            row_in = row_ff + DB'(1);
            if (row_ff + DB'(1) >= h) begin
               full_in = 1'b1;
               pos_in  = '0;
            end
         end else begin
            col_in = col_ff + CB'(1);
         end
      end else if (cmd.drain && full_ff) begin
         if (is_last) begin
            col_in  = '0;
            row_in  = '0;
            full_in = 1'b0;
            pos_in  = '0;
         end else begin
            pos_in = pos_ff + AB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fr90_pkg::CFG_DIM_BITS'(256);
         height_ff <= fr90_pkg::CFG_DIM_BITS'(256);
         cw_ff     <= 1'b1;
         col_ff    <= '0;
         row_ff    <= '0;
         full_ff   <= 1'b0;
         pos_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         cw_ff     <= cw_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         full_ff   <= full_in;
         pos_ff    <= pos_in;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[wr_addr] <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.drain) begin
         rd_data_ff <= store[pos_ff];
         rd_last_ff <= full_ff && is_last;
         rd_nrdy_ff <= !full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pixel_out_ff <= rd_nrdy_ff ? '0 : rd_data_ff;
         last_ff      <= rd_last_ff;
         status_ff    <= rd_nrdy_ff;
      end
   end

   assign pixel_out = pixel_out_ff;
   assign last      = last_ff;
   assign status    = status_ff;

endmodule

FILE: sv/frame_rotate_90_top.sv
// Top level of the 90-degree frame rotator.
// Depends on fr90_pkg, fr90_if, fr90_ctrl and fr90_dp.

// Rotates one frame of up to 256x256 24-bit pixels by 90 degrees. Load
// beats (mode 0) bring source pixels in row-major order; each is written
// straight to its rotated place in an on-chip frame store, one load per
// clock outside a drain's read cycle, and yields no response. Once the
// whole W x H frame is in, drain beats (mode 1) read the rotated frame
// (H wide, W tall) in row-major order, one response each, with last set
// on its final pixel; the block then takes a new frame. Loads past a full
// frame are dropped. A drain before the frame is complete answers status
// 1 with zero pixel and last, and changes nothing. A drain passes through
// the registered store read and then the output register, and no beat is
// taken in the read cycle. A drain waits while the previous response has
// not been taken; loads keep flowing while a response waits. The store
// has no reset and needs no clearing pass: every entry drained was written
// by the current frame. Configuration (width, height, direction) is to be
// written through the csr_ port only while idle; the block does not
// enforce this. A write to width, height or direction restarts the frame.
// Width or height of 0 acts as 1; values above 256 act as 256.
module frame_rotate_90_top (
   input  logic                               clock,
   input  logic                               reset,
   fr90_req_if.sink                           req_bus,
   fr90_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [fr90_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fr90_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   fr90_pkg::fr90_cmd_type cmd;
   logic                   req_ready;
   logic                   rsp_valid;

   // handshakes and read sequencing
   fr90_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // store, counters, address arithmetic, response payload
   fr90_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pixel_in  (req_bus.pixel_in),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pixel_out (rsp_bus.pixel_out),
      .last      (rsp_bus.last),
      .status    (rsp_bus.status)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule
